// ===== rtl/sts_pkg.sv =====
// Shared types and constants for the source token scanner.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int unsigned OFFSET_BITS   = 24;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned CP_BITS       = 21;
  localparam int unsigned WORD_CHARS    = 5;
  localparam int unsigned CHAR_BITS     = 7;

  typedef enum logic [1:0] {
    ST_TOKEN    = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_END_OK   = 2'd2,
    ST_END_FAIL = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    K_PLUS     = 5'd0,
    K_MINUS    = 5'd1,
    K_STAR     = 5'd2,
    K_DSTAR    = 5'd3,
    K_SLASH    = 5'd4,
    K_LPAREN   = 5'd5,
    K_RPAREN   = 5'd6,
    K_COLON    = 5'd7,
    K_SEMI     = 5'd8,
    K_EQUAL    = 5'd9,
    K_INT_LIT  = 5'd10,
    K_FLT_LIT  = 5'd11,
    K_IDENT    = 5'd12,
    K_KW_INT   = 5'd13,
    K_KW_FLOAT = 5'd14,
    K_KW_AUTO  = 5'd15,
    K_KW_CONST = 5'd16,
    K_KW_VAR   = 5'd17
  } kind_e;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_STAR  = 5'b00010,
    MODE_INT   = 5'b00100,
    MODE_FLOAT = 5'b01000,
    MODE_IDENT = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic [2:0]         byte_count;
    logic               end_of_text;
  } in_req_t;

  typedef struct packed {
    status_e                  status;
    kind_e                    token_kind;
    logic [OFFSET_BITS-1:0]   span_start;
    logic [OFFSET_BITS-1:0]   span_end;
    logic [POSITION_BITS-1:0] start_line;
    logic [POSITION_BITS-1:0] start_column;
    logic                     last_of_item;
  } result_t;

  typedef struct packed {
    logic         is_digit;
    logic         is_start;
    logic         is_skip;
    logic         is_newline;
    logic         is_star;
    logic         is_dot;
    logic         is_op;
    kind_e        op_kind;
  } char_class_t;

  // Results of one request: count is 0, 1 or 2, res[0] goes out first
  typedef struct packed {
    logic [1:0]   count;
    result_t [1:0] res;
  } push_t;

endpackage

// ===== rtl/source_token_scanner_unit.sv =====
// Top level of the source token scanner: request register, core and result queue.
//
//  channel  direction  handshake                payload
//  in       input      in_valid_i / in_ready_o  in_req_i  (sts_pkg::in_req_t)
//  out      output     out_valid_o/ out_ready_i out_res_o (sts_pkg::result_t)
//
// One request a cycle while the core can take it: a request is held in the
// request register, scanned combinationally, and its 0 to 2 results land in a 4-entry queue.
// A request moves into the core only while the queue has room for two results,
// so a stalled output holds back the input after three to four requests that
// give results. Results leave one per cycle while out_ready_i is high; the first result
// passes through the request register and then the queue before it is offered.
// Reset clears scan state to line 1, column 1, offset 0; no clearing pass.
`timescale 1ns / 1ps

module source_token_scanner_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sts_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sts_pkg::result_t  out_res_o
);

  sts_pkg::in_req_t req_q;
  logic             req_vld_q;
  logic             room;
  logic             fire;
  sts_pkg::push_t   push;

  assign fire       = req_vld_q && room;
  assign in_ready_o = !req_vld_q || fire;

  // Capture a new request when the register frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      req_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) req_q <= in_req_i;
  end

  sts_scan_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .push_o (push)
  );

  sts_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

endmodule

// ===== rtl/sts_char_class.sv =====
// Character classifier: sorts one code point into the scanner's classes.
`timescale 1ns / 1ps

module sts_char_class (
  input  logic [sts_pkg::CP_BITS-1:0] code_point_i,
  output sts_pkg::char_class_t        cls_o
);

  always_comb begin
    cls_o            = '0;
    cls_o.op_kind    = sts_pkg::K_PLUS;
    cls_o.is_digit   = code_point_i inside {[21'd48:21'd57]};
    cls_o.is_start   = (code_point_i inside {[21'd97:21'd122]}) ||
                       (code_point_i inside {[21'd65:21'd90]}) ||
                       (code_point_i == 21'd95) || (code_point_i == 21'd36);
    // space, tab, vertical tab, carriage return, NUL
    cls_o.is_skip    = code_point_i inside {21'd32, 21'd9, 21'd11, 21'd13, 21'd0};
    cls_o.is_newline = (code_point_i == 21'd10);
    cls_o.is_star    = (code_point_i == 21'd42);
    cls_o.is_dot     = (code_point_i == 21'd46);
    // single-character operators
    cls_o.is_op      = 1'b1;
    case (code_point_i)
      21'd43:  cls_o.op_kind = sts_pkg::K_PLUS;
      21'd45:  cls_o.op_kind = sts_pkg::K_MINUS;
      21'd47:  cls_o.op_kind = sts_pkg::K_SLASH;
      21'd40:  cls_o.op_kind = sts_pkg::K_LPAREN;
      21'd41:  cls_o.op_kind = sts_pkg::K_RPAREN;
      21'd58:  cls_o.op_kind = sts_pkg::K_COLON;
      21'd59:  cls_o.op_kind = sts_pkg::K_SEMI;
      21'd61:  cls_o.op_kind = sts_pkg::K_EQUAL;
      default: cls_o.is_op   = 1'b0;
    endcase
  end

endmodule

// ===== rtl/sts_scan_core.sv =====
// Scanner core: scan state, token assembly and result formation per request.
`timescale 1ns / 1ps

module sts_scan_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  sts_pkg::in_req_t req_i,
  output sts_pkg::push_t   push_o
);

  localparam int unsigned NKW = 5;
  localparam int unsigned OB  = sts_pkg::OFFSET_BITS;
  localparam int unsigned PB  = sts_pkg::POSITION_BITS;
  localparam int unsigned CB  = sts_pkg::CHAR_BITS;
  localparam int unsigned WC  = sts_pkg::WORD_CHARS;
  localparam logic [PB-1:0] POS_MAX = '1;

  typedef logic [WC-1:0][CB-1:0] word_t;

  // keyword texts, zero padded, and their lengths
  localparam word_t KW_TEXT [NKW] = '{
    {7'd0,   7'd0,   7'd116, 7'd110, 7'd105},  // int
    {7'd116, 7'd97,  7'd111, 7'd108, 7'd102},  // float
    {7'd0,   7'd111, 7'd116, 7'd117, 7'd97},   // auto
    {7'd116, 7'd115, 7'd110, 7'd111, 7'd99},   // const
    {7'd0,   7'd0,   7'd114, 7'd97,  7'd118}   // var
  };
  localparam logic [2:0] KW_LEN [NKW] = '{3'd3, 3'd5, 3'd4, 3'd5, 3'd3};
  localparam sts_pkg::kind_e KW_KIND [NKW] = '{
    sts_pkg::K_KW_INT, sts_pkg::K_KW_FLOAT, sts_pkg::K_KW_AUTO,
    sts_pkg::K_KW_CONST, sts_pkg::K_KW_VAR
  };

  sts_pkg::mode_e      mode_q, mode_d;
  logic [OB-1:0]       tok_off_q, tok_off_d;
  logic [PB-1:0]       tok_line_q, tok_line_d;
  logic [PB-1:0]       tok_col_q, tok_col_d;
  logic [OB-1:0]       pos_q, pos_d;
  logic [PB-1:0]       line_q, line_d;
  logic [PB-1:0]       col_q, col_d;
  word_t               word_q, word_d;
  logic [2:0]          wlen_q, wlen_d;
  logic                err_q, err_d;

  sts_pkg::char_class_t cls;
  logic [OB-1:0]       next_pos;
  logic                eot;
  logic                ext_star, ext_int, ext_flt, ext_id, extended;
  logic                bad_char;
  logic                a_vld, b_vld;
  sts_pkg::result_t    res_a, res_b, res_flush;
  sts_pkg::kind_e      flush_kind, word_kind;
  logic [CB-1:0]       ch7;
  logic                kw_hit;

  sts_char_class u_class (
    .code_point_i (req_i.code_point),
    .cls_o        (cls)
  );

  assign eot      = req_i.end_of_text;
  assign next_pos = pos_q + OB'(req_i.byte_count);
  assign ch7      = req_i.code_point[CB-1:0];

  // Extend the held token where the new character allows it
  assign ext_star = !eot && (mode_q == sts_pkg::MODE_STAR) && cls.is_star;
  assign ext_int  = !eot && (mode_q == sts_pkg::MODE_INT) && (cls.is_digit || cls.is_dot);
  assign ext_flt  = !eot && (mode_q == sts_pkg::MODE_FLOAT) && cls.is_digit;
  assign ext_id   = !eot && (mode_q == sts_pkg::MODE_IDENT) &&
                    (cls.is_start || cls.is_digit);
  assign extended = ext_star || ext_int || ext_flt || ext_id;
  assign bad_char = !(cls.is_skip || cls.is_newline || cls.is_op || cls.is_star ||
                      cls.is_digit || cls.is_start);

  // Match the held word against the keyword list
  always_comb begin
    word_kind = sts_pkg::K_IDENT;
    for (int k = 0; k < NKW; k++) begin
      kw_hit = (wlen_q == KW_LEN[k]);
      for (int i = 0; i < WC; i++) begin
        if (i < int'(KW_LEN[k]) && word_q[i] != KW_TEXT[k][i]) kw_hit = 1'b0;
      end
      if (kw_hit) word_kind = KW_KIND[k];
    end
  end

  // Kind of the held token when it closes
  always_comb begin
    case (mode_q)
      sts_pkg::MODE_STAR:  flush_kind = sts_pkg::K_STAR;
      sts_pkg::MODE_INT:   flush_kind = sts_pkg::K_INT_LIT;
      sts_pkg::MODE_FLOAT: flush_kind = sts_pkg::K_FLT_LIT;
      default:             flush_kind = word_kind;
    endcase
  end

  // Form the first result (held token or double star) and the second
  // (operator, bad character or end of text)
  always_comb begin
    res_flush              = '0;
    res_flush.status       = sts_pkg::ST_TOKEN;
    res_flush.token_kind   = flush_kind;
    res_flush.span_start   = tok_off_q;
    res_flush.span_end     = pos_q;
    res_flush.start_line   = tok_line_q;
    res_flush.start_column = tok_col_q;

    res_a = res_flush;
    a_vld = 1'b0;
    if (!err_q) begin
      if (ext_star) begin
        a_vld            = 1'b1;
        res_a.token_kind = sts_pkg::K_DSTAR;
        res_a.span_end   = next_pos;
      end else if (!extended && mode_q != sts_pkg::MODE_IDLE) begin
        a_vld = 1'b1;
      end
    end

    res_b              = '0;
    res_b.token_kind   = sts_pkg::K_PLUS;
    res_b.span_start   = pos_q;
    res_b.span_end     = next_pos;
    res_b.start_line   = line_q;
    res_b.start_column = col_q;
    res_b.status       = sts_pkg::ST_TOKEN;
    b_vld              = 1'b0;
    if (eot) begin
      b_vld          = 1'b1;
      res_b.status   = err_q ? sts_pkg::ST_END_FAIL : sts_pkg::ST_END_OK;
      res_b.span_end = pos_q;
    end else if (!extended) begin
      if (cls.is_op && !err_q) begin
        b_vld            = 1'b1;
        res_b.token_kind = cls.op_kind;
      end else if (bad_char) begin
        b_vld        = 1'b1;
        res_b.status = sts_pkg::ST_BAD_CHAR;
      end
    end

    // Pack the results in order and mark the last one
    push_o = '0;
    res_a.last_of_item = !b_vld;
    res_b.last_of_item = 1'b1;
    if (fire_i) begin
      push_o.count = {1'b0, a_vld} + {1'b0, b_vld};
      push_o.res[0] = a_vld ? res_a : res_b;
      push_o.res[1] = res_b;
    end
  end

  // Next scan state
  always_comb begin
    mode_d     = mode_q;
    tok_off_d  = tok_off_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    pos_d      = next_pos;
    line_d     = line_q;
    col_d      = (col_q == POS_MAX) ? POS_MAX : col_q + PB'(1);
    word_d     = word_q;
    wlen_d     = wlen_q;
    err_d      = err_q;

    if (cls.is_newline && !extended) begin
      line_d = (line_q == POS_MAX) ? POS_MAX : line_q + PB'(1);
      col_d  = PB'(1);
    end

    if (ext_star) begin
      mode_d = sts_pkg::MODE_IDLE;
    end else if (ext_int) begin
      if (cls.is_dot) mode_d = sts_pkg::MODE_FLOAT;
    end else if (ext_id) begin
      if (wlen_q < 3'(WC)) begin
        for (int i = 0; i < WC; i++) begin
          if (wlen_q == 3'(i)) word_d[i] = ch7;
        end
        wlen_d = wlen_q + 3'd1;
      end else begin
        wlen_d = 3'(WC + 1);
      end
    end else if (!extended) begin
      mode_d = sts_pkg::MODE_IDLE;
      if (cls.is_star || cls.is_digit || cls.is_start) begin
        tok_off_d  = pos_q;
        tok_line_d = line_q;
        tok_col_d  = col_q;
      end
      if (cls.is_skip || cls.is_newline || cls.is_op) begin
        mode_d = sts_pkg::MODE_IDLE;
      end else if (cls.is_star) begin
        mode_d = sts_pkg::MODE_STAR;
      end else if (cls.is_digit) begin
        mode_d = sts_pkg::MODE_INT;
      end else if (cls.is_start) begin
        mode_d    = sts_pkg::MODE_IDENT;
        word_d    = '0;
        word_d[0] = ch7;
        wlen_d    = 3'd1;
      end else begin
        err_d = 1'b1;
      end
    end

    // End of text: return to the reset state
    if (eot) begin
      mode_d     = sts_pkg::MODE_IDLE;
      tok_off_d  = '0;
      tok_line_d = PB'(1);
      tok_col_d  = PB'(1);
      pos_d      = '0;
      line_d     = PB'(1);
      col_d      = PB'(1);
      word_d     = '0;
      wlen_d     = '0;
      err_d      = 1'b0;
    end
  end

  // Hold state until a request is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sts_pkg::MODE_IDLE;
      tok_off_q  <= '0;
      tok_line_q <= PB'(1);
      tok_col_q  <= PB'(1);
      pos_q      <= '0;
      line_q     <= PB'(1);
      col_q      <= PB'(1);
      word_q     <= '0;
      wlen_q     <= '0;
      err_q      <= 1'b0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      tok_off_q  <= tok_off_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      pos_q      <= pos_d;
      line_q     <= line_d;
      col_q      <= col_d;
      word_q     <= word_d;
      wlen_q     <= wlen_d;
      err_q      <= err_d;
    end
  end

  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && req_i.end_of_text |=>
      mode_q == sts_pkg::MODE_IDLE && !err_q && pos_q == '0)
    else $error("end of text did not restore scan state");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |->
      push_o.res[1].last_of_item && !push_o.res[0].last_of_item)
    else $error("result pair marked out of order");

  a_err_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && push_o.count != 2'd0 |->
      push_o.res[0].status != sts_pkg::ST_TOKEN)
    else $error("token emitted after bad character");

endmodule

// ===== rtl/sts_result_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready_i is high.
`timescale 1ns / 1ps

module sts_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sts_pkg::push_t    push_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sts_pkg::result_t  out_res_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  sts_pkg::result_t     mem_q [DEPTH];
  logic [PTR_BITS-1:0]  wptr_q, rptr_q;
  logic [CNT_BITS-1:0]  cnt_q;
  logic                 pop;
  logic [PTR_BITS-1:0]  wptr_nx;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_res_o   = mem_q[rptr_q];
  assign room_o      = (cnt_q <= CNT_BITS'(DEPTH - 2));
  assign wptr_nx     = wptr_q + PTR_BITS'(1);

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wptr_q] <= push_i.res[0];
    if (push_i.count == 2'd2) mem_q[wptr_nx] <= push_i.res[1];
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_q + PTR_BITS'(push_i.count);
      if (pop) rptr_q <= rptr_q + PTR_BITS'(1);
      cnt_q <= cnt_q + CNT_BITS'(push_i.count) - CNT_BITS'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |->
      (CNT_BITS + 1)'(cnt_q) + (CNT_BITS + 1)'(push_i.count) <= (CNT_BITS + 1)'(DEPTH))
    else $error("result queue overflow");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.count == 2'd0 |=> cnt_q == $past(cnt_q) - CNT_BITS'(1))
    else $error("result queue count lost a pop");

endmodule
